// ===== rtl/pft_pkg.sv =====
// shared types and constants for the prefix tree engine
package pft_pkg;

  // request kinds, taken from the first letter of a word
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_EXACT  = 2'd1;
  localparam logic [1:0] KIND_PREFIX = 2'd2;

  localparam int LETTER_W = 5;
  // wide enough for the largest alphabet the engine supports
  localparam int CODE_W = 8;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef logic [1:0] kind_t;
  typedef logic [CODE_W-1:0] code_t;

  // classified beat handed from front to back
  typedef struct packed {
    kind_t kind;
    code_t code;
    logic  first;
    logic  last;
    logic  empty;
  } pft_item_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } pft_qstat_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_READ,
    BK_WALK,
    BK_MARK,
    BK_RESULT
  } back_state_t;

endpackage

// ===== rtl/pft_front.sv =====
// front end: accepts input beats and classifies them per word
module pft_front #(
  parameter int ALPHABET_SIZE = 26
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          in_kind,
  input  logic [pft_pkg::LETTER_W-1:0]        in_letter,
  input  logic                                in_last,
  input  logic                                in_empty_req,
  input  pft_pkg::pft_qstat_t                 qstat,
  input  logic                                clearing,
  output logic                                push,
  output pft_pkg::pft_item_t                  item
);
  import pft_pkg::*;

  logic  inside_r, inside_nxt;
  kind_t kind_r, kind_nxt;
  logic  first;
  logic  sat;

  assign busy  = qstat.full | clearing;
  assign push  = start & ~busy;
  assign first = ~inside_r | in_empty_req;
  // out of range letters saturate to the top code
  assign sat   = {4'b0000, in_letter} >= 9'(ALPHABET_SIZE);

  always_comb begin
    item.kind  = first ? in_kind : kind_r;
    item.code  = sat ? CODE_W'(ALPHABET_SIZE - 1) : CODE_W'(in_letter);
    item.first = first;
    item.last  = in_last | in_empty_req;
    item.empty = in_empty_req;
    inside_nxt = inside_r;
    kind_nxt   = kind_r;
    if (push) begin
      if (in_empty_req) begin
        inside_nxt = 1'b0;
      end else begin
        inside_nxt = ~in_last;
        if (first) begin
          kind_nxt = in_kind;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r <= 1'b0;
      kind_r   <= KIND_INSERT;
    end else begin
      inside_r <= inside_nxt;
      kind_r   <= kind_nxt;
    end
  end

endmodule

// ===== rtl/pft_queue.sv =====
// short queue of classified beats between front and back
module pft_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  pft_pkg::pft_item_t  push_item,
  input  logic                pop,
  output pft_pkg::pft_item_t  head,
  output pft_pkg::pft_qstat_t qstat
);
  import pft_pkg::*;

  pft_item_t           slots_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_r, wr_nxt;
  logic [QPTR_W-1:0]   rd_r, rd_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  assign qstat.full  = cnt_r == QCNT_W'(QUEUE_DEPTH);
  assign qstat.empty = cnt_r == '0;
  assign do_push     = push & ~qstat.full;
  assign do_pop      = pop & ~qstat.empty;
  assign head        = slots_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/pft_back.sv =====
// back end: walks the node table, allocates nodes and forms results
module pft_back #(
  parameter int NODE_COUNT    = 1024,
  parameter int ALPHABET_SIZE = 26
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pft_pkg::pft_item_t  head,
  input  pft_pkg::pft_qstat_t qstat,
  output logic                pop,
  output logic                clearing,
  output logic                out_valid,
  output logic                out_answer,
  output logic                out_overflow
);
  import pft_pkg::*;

  localparam int TOTAL  = NODE_COUNT * ALPHABET_SIZE;
  localparam int NODE_W = $clog2(NODE_COUNT);
  localparam int ADDR_W = $clog2(TOTAL);
  localparam int NF_W   = $clog2(NODE_COUNT + 1);

  logic [NODE_W-1:0] child_mem [TOTAL];
  logic              mark_mem  [NODE_COUNT];

  back_state_t       state_r, state_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  logic [NODE_W-1:0] cursor_r, cursor_nxt;
  logic              miss_r, miss_nxt;
  kind_t             wkind_r, wkind_nxt;
  logic [NF_W-1:0]   next_free_r, next_free_nxt;
  code_t             code_r, code_nxt;
  logic              last_r, last_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              answer_r, answer_nxt;
  logic              overflow_r, overflow_nxt;
  logic [NODE_W-1:0] child_q_r;
  logic              mark_q_r;

  logic [ADDR_W-1:0] slot_addr;
  logic              alloc_we;
  logic              mark_set;
  logic              child_we;
  logic [ADDR_W-1:0] child_waddr;
  logic [NODE_W-1:0] child_wdata;
  logic              mark_we;
  logic [NODE_W-1:0] mark_waddr;
  logic              pool_dry;
  logic              miss_eff;

  assign clearing  = state_r == BK_CLEAR;
  assign slot_addr = ADDR_W'(ADDR_W'(cursor_r) * ADDR_W'(ALPHABET_SIZE)) + ADDR_W'(code_r);
  assign pool_dry  = next_free_r >= NF_W'(NODE_COUNT);
  assign miss_eff  = head.first ? 1'b0 : miss_r;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    cursor_nxt    = cursor_r;
    miss_nxt      = miss_r;
    wkind_nxt     = wkind_r;
    next_free_nxt = next_free_r;
    code_nxt      = code_r;
    last_nxt      = last_r;
    out_valid_nxt = 1'b0;
    answer_nxt    = answer_r;
    overflow_nxt  = overflow_r;
    alloc_we      = 1'b0;
    mark_set      = 1'b0;
    pop           = 1'b0;
    case (state_r)
      BK_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == ADDR_W'(TOTAL - 1)) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (!qstat.empty) begin
          pop = 1'b1;
          if (head.empty) begin
            cursor_nxt    = '0;
            miss_nxt      = 1'b0;
            wkind_nxt     = head.kind;
            out_valid_nxt = 1'b1;
            answer_nxt    = 1'b1;
            overflow_nxt  = 1'b0;
          end else begin
            code_nxt = head.code;
            last_nxt = head.last;
            miss_nxt = miss_eff;
            if (head.first) begin
              cursor_nxt = '0;
              wkind_nxt  = head.kind;
            end
            if (!miss_eff) begin
              state_nxt = BK_READ;
            end else if (head.last) begin
              state_nxt = BK_MARK;
            end
          end
        end
      end
      BK_READ: begin
        state_nxt = BK_WALK;
      end
      BK_WALK: begin
        if (child_q_r == '0) begin
          if (wkind_r != KIND_INSERT || pool_dry) begin
            miss_nxt = 1'b1;
          end else begin
            alloc_we      = 1'b1;
            cursor_nxt    = next_free_r[NODE_W-1:0];
            next_free_nxt = next_free_r + 1'b1;
          end
        end else begin
          cursor_nxt = child_q_r;
        end
        state_nxt = last_r ? BK_MARK : BK_IDLE;
      end
      BK_MARK: begin
        mark_set  = (wkind_r == KIND_INSERT) && !miss_r;
        state_nxt = BK_RESULT;
      end
      BK_RESULT: begin
        out_valid_nxt = 1'b1;
        if (wkind_r == KIND_INSERT) begin
          answer_nxt   = ~miss_r;
          overflow_nxt = miss_r;
        end else if (wkind_r == KIND_EXACT) begin
          answer_nxt   = ~miss_r & mark_q_r;
          overflow_nxt = 1'b0;
        end else begin
          answer_nxt   = ~miss_r;
          overflow_nxt = 1'b0;
        end
        state_nxt = BK_IDLE;
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // one shared write port per store: the clearing sweep or the walk
  assign child_we    = clearing | alloc_we;
  assign child_waddr = clearing ? clr_r : slot_addr;
  assign child_wdata = clearing ? '0 : next_free_r[NODE_W-1:0];
  assign mark_we     = (clearing && (clr_r < ADDR_W'(NODE_COUNT))) | mark_set;
  assign mark_waddr  = clearing ? clr_r[NODE_W-1:0] : cursor_r;

  always_ff @(posedge clk) begin
    if (child_we) begin
      child_mem[child_waddr] <= child_wdata;
    end
    child_q_r <= child_mem[slot_addr];
  end

  always_ff @(posedge clk) begin
    if (mark_we) begin
      mark_mem[mark_waddr] <= ~clearing;
    end
    mark_q_r <= mark_mem[cursor_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLEAR;
      clr_r       <= '0;
      cursor_r    <= '0;
      miss_r      <= 1'b0;
      wkind_r     <= KIND_INSERT;
      next_free_r <= NF_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cursor_r    <= cursor_nxt;
      miss_r      <= miss_nxt;
      wkind_r     <= wkind_nxt;
      next_free_r <= next_free_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r     <= code_nxt;
    last_r     <= last_nxt;
    answer_r   <= answer_nxt;
    overflow_r <= overflow_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_answer   = answer_r;
  assign out_overflow = overflow_r;

  a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !pop)
    else $error("queue popped during clearing sweep");

  a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
    next_free_r <= NF_W'(NODE_COUNT))
    else $error("node pool counter past capacity");

  a_alloc_bumps_pool: assert property (@(posedge clk) disable iff (!rst_n)
    alloc_we |=> next_free_r == $past(next_free_r) + 1'b1)
    else $error("allocation without pool advance");

  a_cursor_allocated: assert property (@(posedge clk) disable iff (!rst_n)
    NF_W'(cursor_r) < next_free_r)
    else $error("cursor on an unallocated node");

  a_result_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(answer_r && overflow_r))
    else $error("result both stored and overflowed");

endmodule

// ===== rtl/prefix_tree_engine.sv =====
// top level of the prefix tree engine: front, queue and back
//
//  channel  ports                                            beat taken when
//  -------  -----------------------------------------------  ---------------------------
//  input    start busy in_kind in_letter in_last in_empty_req start high and busy low
//  result   out_valid out_answer out_overflow                 every cycle out_valid is high
//
// a letter goes through these back-end steps in order: the pop from the queue,
// a child table read, then the walk with an optional allocation write; the last
// letter of a word adds the word-end mark read or write and the result register
// an empty word is answered at its pop; after a miss a letter skips read and walk
// after reset a clearing sweep over all NODE_COUNT*ALPHABET_SIZE slots (26624 at
// the defaults) zeroes the child table and word-end marks, busy held high
// the front keeps taking beats into a two-entry queue while the back walks
// results show for one cycle; the receiver cannot stall them
module prefix_tree_engine #(
  parameter int NODE_COUNT    = 1024,
  parameter int ALPHABET_SIZE = 26
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_kind,
  input  logic [pft_pkg::LETTER_W-1:0] in_letter,
  input  logic                         in_last,
  input  logic                         in_empty_req,
  output logic                         out_valid,
  output logic                         out_answer,
  output logic                         out_overflow
);
  import pft_pkg::*;

  // classified beat from the front and the head of the queue
  pft_item_t  push_item;
  pft_item_t  head;
  pft_qstat_t qstat;
  logic       push;
  logic       pop;
  // high for the whole sweep after reset
  logic       clearing;

  // front: handshake, word tracking, letter saturation
  pft_front #(
    .ALPHABET_SIZE(ALPHABET_SIZE)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_kind     (in_kind),
    .in_letter   (in_letter),
    .in_last     (in_last),
    .in_empty_req(in_empty_req),
    .qstat       (qstat),
    .clearing    (clearing),
    .push        (push),
    .item        (push_item)
  );

  // decoupling queue, lets the front run ahead of the walk
  pft_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_item(push_item),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  // back: node table walk, pool allocation, word-end marks, results
  pft_back #(
    .NODE_COUNT   (NODE_COUNT),
    .ALPHABET_SIZE(ALPHABET_SIZE)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .qstat       (qstat),
    .pop         (pop),
    .clearing    (clearing),
    .out_valid   (out_valid),
    .out_answer  (out_answer),
    .out_overflow(out_overflow)
  );

endmodule
